### hdl/vqdm_pkg.sv
// ----------------------------------------------------------------------------
// vqdm_pkg
// Shared types and constants of the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;

    localparam int unsigned QSIZE_W   = 5;
    localparam int unsigned LIMIT_W   = 23;
    localparam int unsigned CFG_W     = 23;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned AVAIL_W   = 16;
    localparam int unsigned OUT_IDX_W = 4;

    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 23'd5000000;

    localparam logic CFG_QUEUE_SIZE = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    typedef logic [2:0] t_status;

    localparam t_status STAT_POSTED    = 3'd0;
    localparam t_status STAT_NOT_READY = 3'd1;
    localparam t_status STAT_NO_DESC   = 3'd2;
    localparam t_status STAT_COMPLETED = 3'd3;
    localparam t_status STAT_WAITING   = 3'd4;
    localparam t_status STAT_TIMEOUT   = 3'd5;
    localparam t_status STAT_NOTHING   = 3'd6;
    localparam t_status STAT_BUSY      = 3'd7;

    localparam logic [1:0] FLAG_NEXT  = 2'd1;
    localparam logic [1:0] FLAG_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]        flags;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
    } t_desc;

    localparam int unsigned DESC_W = $bits(t_desc);

endpackage

### hdl/vqdm_ram.sv
// ----------------------------------------------------------------------------
// vqdm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vqdm_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/virtqueue_descriptor_manager_core.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_core
// Driver side of a split virtqueue: descriptor free list, avail ring posting
// and used index polling with a timeout budget.
// ----------------------------------------------------------------------------
// Each item returns exactly one result, shown for one cycle with o_valid; the
// receiver cannot stall it. Items are taken while o_busy is low. A submit runs
// through accept, two dependent pops through the registered read port of the
// link RAM, then the fill and post; a completing or timed-out poll adds a
// push step after accept (two pushes share the one link write port); every
// other item is answered from accept alone. A queue_size write starts a
// rebuild of the free list that walks all QUEUE_DEPTH link RAM entries, one
// entry a cycle, with o_busy high and o_cfg_ready low. A single incrementer/
// decrementer serves the avail index, the poll budget and the rebuild counter.
module virtqueue_descriptor_manager_core #(
    parameter int unsigned QUEUE_DEPTH = vqdm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_opcode,
    input  logic [vqdm_pkg::ADDR_W-1:0]         i_cmd_addr,
    input  logic [vqdm_pkg::LEN_W-1:0]          i_cmd_len,
    input  logic [vqdm_pkg::ADDR_W-1:0]         i_resp_addr,
    input  logic [vqdm_pkg::LEN_W-1:0]          i_resp_len,
    input  logic [vqdm_pkg::AVAIL_W-1:0]        i_used_index,
    output logic                                o_valid,
    output logic [2:0]                          o_status,
    output logic [vqdm_pkg::OUT_IDX_W-1:0]      o_cmd_desc,
    output logic [vqdm_pkg::OUT_IDX_W-1:0]      o_resp_desc,
    output logic [vqdm_pkg::OUT_IDX_W-1:0]      o_ring_slot,
    output logic [vqdm_pkg::AVAIL_W-1:0]        o_avail_index,
    output logic                                o_notify,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [vqdm_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned LINK_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned LIMIT_W = vqdm_pkg::LIMIT_W;
    localparam int unsigned AVAIL_W = vqdm_pkg::AVAIL_W;
    localparam int unsigned OIDX_W  = vqdm_pkg::OUT_IDX_W;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POP1  = 3'd1;
    localparam logic [2:0] ST_POP2  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_BUILD = 3'd5;

    logic [2:0]         r_state,      n_state;
    logic [LINK_W-1:0]  r_free_head,  n_free_head;
    logic [LINK_W-1:0]  r_eff,        n_eff;
    logic [LIMIT_W-1:0] r_limit,      n_limit;
    logic [AVAIL_W-1:0] r_avail,      n_avail;
    logic               r_pending,    n_pending;
    logic [AVAIL_W-1:0] r_pend_avail, n_pend_avail;
    logic [IDX_W-1:0]   r_pend_cmd,   n_pend_cmd;
    logic [IDX_W-1:0]   r_pend_resp,  n_pend_resp;
    logic [LIMIT_W-1:0] r_budget,     n_budget;
    logic [IDX_W-1:0]   r_idx,        n_idx;
    logic [IDX_W-1:0]   r_slot,       n_slot;

    logic                  r_valid,     n_valid;
    vqdm_pkg::t_status     r_status,    n_status;
    logic [OIDX_W-1:0]     r_cmd_desc,  n_cmd_desc;
    logic [OIDX_W-1:0]     r_resp_desc, n_resp_desc;
    logic [OIDX_W-1:0]     r_ring_slot, n_ring_slot;
    logic [AVAIL_W-1:0]    r_out_avail, n_out_avail;
    logic                  r_notify,    n_notify;

    logic [vqdm_pkg::ADDR_W-1:0] r_cmd_addr;
    logic [vqdm_pkg::LEN_W-1:0]  r_cmd_len;
    logic [vqdm_pkg::ADDR_W-1:0] r_resp_addr;
    logic [vqdm_pkg::LEN_W-1:0]  r_resp_len;

    logic               accept;
    logic               cfg_acc;
    logic [LINK_W-1:0]  cfg_clamp;
    logic [LINK_W-1:0]  cfg_eff;
    logic [IDX_W-1:0]   w_mask;
    logic [IDX_W-1:0]   w_slot;

    logic [LIMIT_W-1:0] alu_a;
    logic               alu_dec;
    logic [LIMIT_W-1:0] alu_y;

    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [LINK_W-1:0]  link_wdata;
    logic [IDX_W-1:0]   link_raddr;
    logic [LINK_W-1:0]  w_link_rd;

    logic               desc_we;
    logic [IDX_W-1:0]   desc_waddr;
    vqdm_pkg::t_desc    desc_wdata;
    vqdm_pkg::t_desc    w_desc_rd;

    logic               ring_we;
    logic [IDX_W-1:0]   w_ring_rd;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;
    assign accept      = i_start && (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign w_mask = IDX_W'(r_eff - LINK_W'(1));
    assign w_slot = r_avail[IDX_W-1:0] & w_mask;

    always_comb begin
        unique case (r_state)
            ST_FILL: begin
                alu_a   = LIMIT_W'(r_avail);
                alu_dec = 1'b0;
            end
            ST_BUILD: begin
                alu_a   = LIMIT_W'(r_idx);
                alu_dec = 1'b0;
            end
            default: begin
                alu_a   = r_budget;
                alu_dec = 1'b1;
            end
        endcase
    end

    assign alu_y = alu_dec ? (alu_a - LIMIT_W'(1)) : (alu_a + LIMIT_W'(1));

    always_comb begin
        if (32'(i_cfg_data[vqdm_pkg::QSIZE_W-1:0]) > QUEUE_DEPTH) begin
            cfg_clamp = LINK_W'(QUEUE_DEPTH);
        end else begin
            cfg_clamp = LINK_W'(i_cfg_data[vqdm_pkg::QSIZE_W-1:0]);
        end
        cfg_eff = '0;
        for (int k = 0; k < LINK_W; k++) begin
            if (cfg_clamp[k]) begin
                cfg_eff = LINK_W'(1) << k;
            end
        end
    end

    always_comb begin
        logic retire;
        retire       = 1'b0;
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_eff        = r_eff;
        n_limit      = r_limit;
        n_avail      = r_avail;
        n_pending    = r_pending;
        n_pend_avail = r_pend_avail;
        n_pend_cmd   = r_pend_cmd;
        n_pend_resp  = r_pend_resp;
        n_budget     = r_budget;
        n_idx        = r_idx;
        n_slot       = r_slot;

        n_valid      = 1'b0;
        n_status     = r_status;
        n_cmd_desc   = '0;
        n_resp_desc  = '0;
        n_ring_slot  = '0;
        n_out_avail  = r_avail;
        n_notify     = 1'b0;

        link_we    = 1'b0;
        link_waddr = r_pend_cmd;
        link_wdata = r_free_head;
        link_raddr = r_free_head[IDX_W-1:0];
        desc_we    = 1'b0;
        desc_waddr = r_pend_cmd;
        desc_wdata = '{flags: vqdm_pkg::FLAG_NEXT, len: r_cmd_len, addr: r_cmd_addr};
        ring_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_acc) begin
                    if (i_cfg_index == vqdm_pkg::CFG_QUEUE_SIZE) begin
                        n_eff        = cfg_eff;
                        n_free_head  = (cfg_eff != '0) ? '0 : LINK_NULL;
                        n_avail      = '0;
                        n_pending    = 1'b0;
                        n_pend_avail = '0;
                        n_pend_cmd   = '0;
                        n_pend_resp  = '0;
                        n_budget     = '0;
                        n_idx        = '0;
                        n_state      = ST_BUILD;
                    end else begin
                        n_limit = i_cfg_data[LIMIT_W-1:0];
                    end
                end else if (accept) begin
                    if (i_opcode == vqdm_pkg::OP_SUBMIT) begin
                        if (r_eff == '0) begin
                            n_valid  = 1'b1;
                            n_status = vqdm_pkg::STAT_NOT_READY;
                        end else if (r_pending) begin
                            n_valid  = 1'b1;
                            n_status = vqdm_pkg::STAT_BUSY;
                        end else if (r_free_head == LINK_NULL) begin
                            n_valid  = 1'b1;
                            n_status = vqdm_pkg::STAT_NO_DESC;
                        end else begin
                            n_state = ST_POP1;
                        end
                    end else begin
                        n_valid = 1'b1;
                        if (!r_pending) begin
                            n_status = vqdm_pkg::STAT_NOTHING;
                        end else begin
                            n_cmd_desc  = OIDX_W'(r_pend_cmd);
                            n_resp_desc = OIDX_W'(r_pend_resp);
                            if (i_used_index != r_pend_avail) begin
                                n_status = vqdm_pkg::STAT_COMPLETED;
                                retire   = 1'b1;
                            end else if (r_budget[LIMIT_W-1:1] == '0) begin
                                n_status = vqdm_pkg::STAT_TIMEOUT;
                                retire   = 1'b1;
                            end else begin
                                n_status = vqdm_pkg::STAT_WAITING;
                                n_budget = alu_y;
                            end
                            if (retire) begin
                                link_we     = 1'b1;
                                link_waddr  = r_pend_cmd;
                                link_wdata  = r_free_head;
                                n_free_head = LINK_W'(r_pend_cmd);
                                n_pending   = 1'b0;
                                n_budget    = '0;
                                n_state     = ST_PUSH;
                            end
                        end
                    end
                end
            end
            ST_POP1: begin
                link_raddr = w_link_rd[IDX_W-1:0];
                if (w_link_rd == LINK_NULL) begin
                    n_valid  = 1'b1;
                    n_status = vqdm_pkg::STAT_NO_DESC;
                    n_state  = ST_IDLE;
                end else begin
                    n_pend_cmd  = r_free_head[IDX_W-1:0];
                    n_free_head = w_link_rd;
                    n_state     = ST_POP2;
                end
            end
            ST_POP2: begin
                n_pend_resp = r_free_head[IDX_W-1:0];
                n_free_head = w_link_rd;
                link_we     = 1'b1;
                link_waddr  = r_pend_cmd;
                link_wdata  = r_free_head;
                desc_we     = 1'b1;
                desc_waddr  = r_pend_cmd;
                n_state     = ST_FILL;
            end
            ST_FILL: begin
                link_we      = 1'b1;
                link_waddr   = r_pend_resp;
                link_wdata   = LINK_NULL;
                desc_we      = 1'b1;
                desc_waddr   = r_pend_resp;
                desc_wdata   = '{flags: vqdm_pkg::FLAG_WRITE, len: r_resp_len,
                                 addr: r_resp_addr};
                ring_we      = 1'b1;
                n_slot       = w_slot;
                n_pend_avail = r_avail;
                n_avail      = alu_y[AVAIL_W-1:0];
                n_pending    = 1'b1;
                n_budget     = r_limit;
                n_valid      = 1'b1;
                n_status     = vqdm_pkg::STAT_POSTED;
                n_cmd_desc   = OIDX_W'(r_pend_cmd);
                n_resp_desc  = OIDX_W'(r_pend_resp);
                n_ring_slot  = OIDX_W'(w_slot);
                n_out_avail  = alu_y[AVAIL_W-1:0];
                n_notify     = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_PUSH: begin
                link_we     = 1'b1;
                link_waddr  = r_pend_resp;
                link_wdata  = LINK_W'(r_pend_cmd);
                n_free_head = LINK_W'(r_pend_resp);
                n_state     = ST_IDLE;
            end
            ST_BUILD: begin
                link_we    = 1'b1;
                link_waddr = r_idx;
                link_wdata = (alu_y[LINK_W-1:0] < r_eff) ? alu_y[LINK_W-1:0] : LINK_NULL;
                n_idx      = alu_y[IDX_W-1:0];
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_head  <= '0;
            r_eff        <= '0;
            r_limit      <= vqdm_pkg::TIMEOUT_RESET;
            r_avail      <= '0;
            r_pending    <= 1'b0;
            r_pend_avail <= '0;
            r_pend_cmd   <= '0;
            r_pend_resp  <= '0;
            r_budget     <= '0;
            r_idx        <= '0;
            r_slot       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_eff        <= n_eff;
            r_limit      <= n_limit;
            r_avail      <= n_avail;
            r_pending    <= n_pending;
            r_pend_avail <= n_pend_avail;
            r_pend_cmd   <= n_pend_cmd;
            r_pend_resp  <= n_pend_resp;
            r_budget     <= n_budget;
            r_idx        <= n_idx;
            r_slot       <= n_slot;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_cmd_desc  <= n_cmd_desc;
        r_resp_desc <= n_resp_desc;
        r_ring_slot <= n_ring_slot;
        r_out_avail <= n_out_avail;
        r_notify    <= n_notify;
        if (accept && (i_opcode == vqdm_pkg::OP_SUBMIT)) begin
            r_cmd_addr  <= i_cmd_addr;
            r_cmd_len   <= i_cmd_len;
            r_resp_addr <= i_resp_addr;
            r_resp_len  <= i_resp_len;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_cmd_desc    = r_cmd_desc;
    assign o_resp_desc   = r_resp_desc;
    assign o_ring_slot   = r_ring_slot;
    assign o_avail_index = r_out_avail;
    assign o_notify      = r_notify;

    vqdm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_waddr),
        .i_wr_data (link_wdata),
        .i_rd_addr (link_raddr),
        .o_rd_data (w_link_rd)
    );

    vqdm_ram #(
        .WIDTH (vqdm_pkg::DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_desc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (desc_we),
        .i_wr_addr (desc_waddr),
        .i_wr_data (desc_wdata),
        .i_rd_addr (r_pend_resp),
        .o_rd_data (w_desc_rd)
    );

    vqdm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_wr_addr (w_slot),
        .i_wr_data (r_pend_cmd),
        .i_rd_addr (r_slot),
        .o_rd_data (w_ring_rd)
    );

    a_ring_holds_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state, 2) == ST_FILL) && r_pending |-> w_ring_rd == r_pend_cmd)
        else $error("avail ring slot does not hold the posted command descriptor");

    a_resp_desc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state, 2) == ST_FILL) && r_pending
            |-> w_desc_rd.flags == vqdm_pkg::FLAG_WRITE)
        else $error("response descriptor not marked device writable");

    a_pending_off_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_free_head != LINK_W'(r_pend_cmd))
                   && (r_free_head != LINK_W'(r_pend_resp)))
        else $error("in-flight descriptor found at the free list head");

    a_post_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |=> o_valid && o_notify && r_pending)
        else $error("post did not raise result, notify and pending together");

endmodule

### test/virtqueue_descriptor_manager_core_tb.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_core_tb
// Self-checking bench for the split virtqueue descriptor manager. A shadow
// copy of the free list, avail counter and pending request predicts the
// result of every accepted submit or poll. Directed tests cover the corner
// cases. Random phases then reconfigure the queue and run submit/poll
// sequences, with noise items and bursty start traffic mixed in.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ADDR_W    = vqdm_pkg::ADDR_W;
    localparam int unsigned LEN_W     = vqdm_pkg::LEN_W;
    localparam int unsigned AVAIL_W   = vqdm_pkg::AVAIL_W;
    localparam int unsigned OUT_IDX_W = vqdm_pkg::OUT_IDX_W;
    localparam int unsigned LIMIT_W   = vqdm_pkg::LIMIT_W;
    localparam int unsigned CFG_W     = vqdm_pkg::CFG_W;
    localparam int unsigned QSIZE_W   = vqdm_pkg::QSIZE_W;

    localparam int unsigned DEPTH       = vqdm_pkg::DEF_QUEUE_DEPTH;
    localparam logic [4:0]  NULL_LINK   = 5'(DEPTH);
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEM_TARGET = 950;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  cmd_addr;
        logic [LEN_W-1:0]   cmd_len;
        logic [ADDR_W-1:0]  resp_addr;
        logic [LEN_W-1:0]   resp_len;
        logic [AVAIL_W-1:0] used_index;
    } t_vq_item;

    typedef struct packed {
        vqdm_pkg::t_status    status;
        logic [OUT_IDX_W-1:0] cmd_desc;
        logic [OUT_IDX_W-1:0] resp_desc;
        logic [OUT_IDX_W-1:0] ring_slot;
        logic [AVAIL_W-1:0]   avail_index;
        logic                 notify;
    } t_vq_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_start      = 1'b0;
    logic                 i_opcode     = 1'b0;
    logic [ADDR_W-1:0]    i_cmd_addr   = '0;
    logic [LEN_W-1:0]     i_cmd_len    = '0;
    logic [ADDR_W-1:0]    i_resp_addr  = '0;
    logic [LEN_W-1:0]     i_resp_len   = '0;
    logic [AVAIL_W-1:0]   i_used_index = '0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 i_cfg_index  = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [2:0]           o_status;
    logic [OUT_IDX_W-1:0] o_cmd_desc;
    logic [OUT_IDX_W-1:0] o_resp_desc;
    logic [OUT_IDX_W-1:0] o_ring_slot;
    logic [AVAIL_W-1:0]   o_avail_index;
    logic                 o_notify;
    logic                 o_cfg_ready;

    // shadow queue state
    logic [4:0]         next_free [DEPTH];
    logic [4:0]         free_top;
    logic [4:0]         ring_size;
    logic [LIMIT_W-1:0] budget_reload;
    logic [AVAIL_W-1:0] avail_count;
    logic [AVAIL_W-1:0] posted_index;
    logic               req_open;
    logic [3:0]         open_cmd;
    logic [3:0]         open_resp;
    logic [LIMIT_W-1:0] budget_left;

    t_vq_result  awaited [$];
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned stalled    = 0;
    int          mismatches = 0;

    virtqueue_descriptor_manager_core #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_opcode     (i_opcode),
        .i_cmd_addr   (i_cmd_addr),
        .i_cmd_len    (i_cmd_len),
        .i_resp_addr  (i_resp_addr),
        .i_resp_len   (i_resp_len),
        .i_used_index (i_used_index),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_cmd_desc   (o_cmd_desc),
        .o_resp_desc  (o_resp_desc),
        .o_ring_slot  (o_ring_slot),
        .o_avail_index(o_avail_index),
        .o_notify     (o_notify),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void chain_free_list(int unsigned n);
        int unsigned i;
        for (i = 0; i < DEPTH; i++) begin
            next_free[i] = (i + 1 < n) ? 5'(i + 1) : NULL_LINK;
        end
        free_top = (n > 0) ? 5'd0 : NULL_LINK;
    endfunction

    function automatic logic [4:0] take_desc();
        logic [4:0] d;
        d = free_top;
        if (d >= NULL_LINK) begin
            return NULL_LINK;
        end
        free_top = next_free[d[3:0]];
        next_free[d[3:0]] = NULL_LINK;
        return d;
    endfunction

    function automatic void give_desc(logic [3:0] d);
        next_free[d] = free_top;
        free_top = {1'b0, d};
    endfunction

    function automatic logic [4:0] usable_size(logic [QSIZE_W-1:0] v);
        logic [4:0] p;
        if (v > DEPTH) begin
            v = QSIZE_W'(DEPTH);
        end
        if (v == 0) begin
            return 5'd0;
        end
        p = 5'd1;
        while (p * 2 <= v) begin
            p = p * 2;
        end
        return p;
    endfunction

    function automatic void apply_register(logic idx, logic [CFG_W-1:0] data);
        if (idx == vqdm_pkg::CFG_QUEUE_SIZE) begin
            ring_size = usable_size(data[QSIZE_W-1:0]);
            chain_free_list(ring_size);
            avail_count  = '0;
            req_open     = 1'b0;
            posted_index = '0;
            open_cmd     = '0;
            open_resp    = '0;
            budget_left  = '0;
        end else begin
            budget_reload = data[LIMIT_W-1:0];
        end
    endfunction

    function automatic t_vq_result step_queue(t_vq_item it);
        t_vq_result r;
        logic [4:0] c;
        logic [4:0] d;
        r = '0;
        if (it.op == vqdm_pkg::OP_SUBMIT) begin
            if (ring_size == 0) begin
                r.status = vqdm_pkg::STAT_NOT_READY;
            end else if (req_open) begin
                r.status = vqdm_pkg::STAT_BUSY;
            end else begin
                c = take_desc();
                d = NULL_LINK;
                if (c != NULL_LINK) begin
                    d = take_desc();
                end
                if (c == NULL_LINK) begin
                    r.status = vqdm_pkg::STAT_NO_DESC;
                end else if (d == NULL_LINK) begin
                    give_desc(c[3:0]);
                    r.status = vqdm_pkg::STAT_NO_DESC;
                end else begin
                    next_free[c[3:0]] = d;
                    next_free[d[3:0]] = NULL_LINK;
                    r.ring_slot  = 4'(avail_count & (ring_size - 1));
                    posted_index = avail_count;
                    avail_count  = avail_count + 1'b1;
                    req_open     = 1'b1;
                    open_cmd     = c[3:0];
                    open_resp    = d[3:0];
                    budget_left  = budget_reload;
                    r.cmd_desc   = c[3:0];
                    r.resp_desc  = d[3:0];
                    r.notify     = 1'b1;
                    r.status     = vqdm_pkg::STAT_POSTED;
                end
            end
        end else if (!req_open) begin
            r.status = vqdm_pkg::STAT_NOTHING;
        end else begin
            r.cmd_desc  = open_cmd;
            r.resp_desc = open_resp;
            if (it.used_index != posted_index) begin
                r.status = vqdm_pkg::STAT_COMPLETED;
            end else if (budget_left <= 1) begin
                r.status = vqdm_pkg::STAT_TIMEOUT;
            end else begin
                budget_left = budget_left - 1'b1;
                r.status = vqdm_pkg::STAT_WAITING;
            end
            if (r.status != vqdm_pkg::STAT_WAITING) begin
                give_desc(open_cmd);
                give_desc(open_resp);
                req_open    = 1'b0;
                budget_left = '0;
            end
        end
        r.avail_index = avail_count;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic t_vq_item submit_item(logic [ADDR_W-1:0] ca, logic [LEN_W-1:0] cl,
                                             logic [ADDR_W-1:0] ra, logic [LEN_W-1:0] rl);
        t_vq_item it;
        it            = '0;
        it.op         = vqdm_pkg::OP_SUBMIT;
        it.cmd_addr   = ca;
        it.cmd_len    = cl;
        it.resp_addr  = ra;
        it.resp_len   = rl;
        it.used_index = AVAIL_W'($urandom);
        return it;
    endfunction

    function automatic t_vq_item random_submit();
        return submit_item(pick_addr(), pick_len(), pick_addr(), pick_len());
    endfunction

    function automatic t_vq_item poll_item(logic [AVAIL_W-1:0] used);
        t_vq_item it;
        it            = random_submit();
        it.op         = vqdm_pkg::OP_POLL;
        it.used_index = used;
        return it;
    endfunction

    function automatic t_vq_item noise_item();
        t_vq_item it;
        it    = random_submit();
        it.op = 1'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            it.used_index = posted_index;
        end
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic send_item(input t_vq_item it);
        int unsigned gap;
        i_start      <= 1'b1;
        i_opcode     <= it.op;
        i_cmd_addr   <= it.cmd_addr;
        i_cmd_len    <= it.cmd_len;
        i_resp_addr  <= it.resp_addr;
        i_resp_len   <= it.resp_len;
        i_used_index <= it.used_index;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        awaited.push_back(step_queue(it));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_start <= 1'b0;
        while (awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_unconfigured();
        send_item(submit_item('1, '1, '1, '1));
        send_item(poll_item('1));
    endtask

    task automatic test_timeout_zero();
        write_reg(vqdm_pkg::CFG_TIMEOUT, '0);
        write_reg(vqdm_pkg::CFG_QUEUE_SIZE, CFG_W'(2));
        send_item(submit_item('0, '0, '0, '0));
        send_item(poll_item(posted_index));
    endtask

    task automatic test_busy();
        send_item(random_submit());
        send_item(random_submit());
        send_item(poll_item(posted_index ^ 16'hFFFF));
    endtask

    task automatic test_one_descriptor();
        write_reg(vqdm_pkg::CFG_QUEUE_SIZE, CFG_W'(1));
        send_item(random_submit());
        send_item(poll_item(posted_index));
    endtask

    task automatic test_size_clamp();
        write_reg(vqdm_pkg::CFG_QUEUE_SIZE, '1);
        send_item(random_submit());
        send_item(poll_item(posted_index ^ 16'h0001));
    endtask

    task automatic test_size_round_down();
        write_reg(vqdm_pkg::CFG_QUEUE_SIZE, CFG_W'(3));
        repeat (3) begin
            send_item(random_submit());
            send_item(poll_item(posted_index ^ 16'h0001));
        end
    endtask

    task automatic test_budget_edge();
        write_reg(vqdm_pkg::CFG_TIMEOUT, CFG_W'(3));
        write_reg(vqdm_pkg::CFG_QUEUE_SIZE, CFG_W'(4));
        send_item(random_submit());
        send_item(poll_item(posted_index));
        send_item(poll_item(posted_index));
        send_item(poll_item(posted_index ^ 16'h8000));
        write_reg(vqdm_pkg::CFG_TIMEOUT, '1);
        send_item(random_submit());
        send_item(poll_item(posted_index));
    endtask

    task automatic run_request();
        int unsigned polls;
        polls = 0;
        send_item(random_submit());
        while (req_open) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_submit());
            end else if (polls >= 10 || $urandom_range(0, 3) == 0) begin
                send_item(poll_item(posted_index ^ AVAIL_W'($urandom_range(1, 65535))));
            end else begin
                send_item(poll_item(posted_index));
            end
            polls++;
        end
    endtask

    task automatic test_random();
        logic [QSIZE_W-1:0] qsize;
        logic [CFG_W-1:0]   data;
        int unsigned        phase_end;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 0) begin
                write_reg(vqdm_pkg::CFG_TIMEOUT, pick_limit());
            end
            qsize = ring_size;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: qsize = '0;
                    1: qsize = QSIZE_W'(1);
                    2: qsize = QSIZE_W'($urandom_range(17, 31));
                    default: qsize = QSIZE_W'($urandom_range(2, 16));
                endcase
                data = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : '0;
                data[QSIZE_W-1:0] = qsize;
                write_reg(vqdm_pkg::CFG_QUEUE_SIZE, data);
            end
            phase_end = items_sent + ((ring_size < 2) ? 8 : 80);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_item(noise_item());
                end else begin
                    run_request();
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_vq_result want;
        if (i_rst_n && o_valid) begin
            if (awaited.size() == 0) begin
                flag_mismatch("unexpected result", 16'(o_status), '0);
            end else begin
                want = awaited.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", 16'(o_status), 16'(want.status));
                if (o_cmd_desc !== want.cmd_desc)
                    flag_mismatch("cmd_desc", 16'(o_cmd_desc), 16'(want.cmd_desc));
                if (o_resp_desc !== want.resp_desc)
                    flag_mismatch("resp_desc", 16'(o_resp_desc), 16'(want.resp_desc));
                if (o_ring_slot !== want.ring_slot)
                    flag_mismatch("ring_slot", 16'(o_ring_slot), 16'(want.ring_slot));
                if (o_avail_index !== want.avail_index)
                    flag_mismatch("avail_index", o_avail_index, want.avail_index);
                if (o_notify !== want.notify)
                    flag_mismatch("notify", 16'(o_notify), 16'(want.notify));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stalled = 0;
        end else begin
            stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        ring_size     = '0;
        budget_reload = vqdm_pkg::TIMEOUT_RESET;
        chain_free_list(DEPTH);
        avail_count   = '0;
        posted_index  = '0;
        req_open      = 1'b0;
        open_cmd      = '0;
        open_resp     = '0;
        budget_left   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unconfigured();
        test_timeout_zero();
        test_busy();
        test_one_descriptor();
        test_size_clamp();
        test_size_round_down();
        test_budget_edge();
        test_random();
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### virtqueue_descriptor_manager_core.f
hdl/vqdm_pkg.sv
hdl/vqdm_ram.sv
hdl/virtqueue_descriptor_manager_core.sv
test/virtqueue_descriptor_manager_core_tb.sv
